### sv/rlt_pkg.sv
// shared types, codes and defaults for the address range table
`timescale 1ns / 1ps

package rlt_pkg;

  localparam int unsigned ENTRIES_DEF = 1024;
  localparam int unsigned BUCKETS_DEF = 10000;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned BKT_W  = 16;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  // one classified word between front and back
  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last;
    logic [TAG_W-1:0]  tag;
    logic [BKT_W-1:0]  bkt;
  } item_t;

endpackage

### sv/ip_range_table_lookup.sv
// top level of the address range table with lookup by address
//
//   port group                       dir  handshake     word
//   command, range_*, entry_tag,     in   push / full   one insert or lookup
//     query_addr
//   status, match_tag                out  empty / pop   one result per word
//
// an insert passes the multiply, subtract and fix steps in the front, which reduce the
// begin address to its bucket by a reciprocal multiply, and is written in the back; a
// lookup goes straight through the front and scans the range memory in the back, one
// entry a cycle, but on an empty table it is answered as a miss without a scan.
// a two-word queue lets the front take the next word while the back scans.
// reset empties the table and the queue; the range memory itself is not cleared.
// a result waiting on pop holds the back, the front and queue keep filling until the queue is full.
`timescale 1ns / 1ps

module ip_range_table_lookup #(
  parameter int unsigned ENTRIES = rlt_pkg::ENTRIES_DEF,
  parameter int unsigned BUCKETS = rlt_pkg::BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       command,
  input  logic [rlt_pkg::ADDR_W-1:0] range_begin,
  input  logic [rlt_pkg::ADDR_W-1:0] range_end,
  input  logic [rlt_pkg::TAG_W-1:0]  entry_tag,
  input  logic [rlt_pkg::ADDR_W-1:0] query_addr,
  output logic                       empty,
  input  logic                       pop,
  output logic [rlt_pkg::STAT_W-1:0] status,
  output logic [rlt_pkg::TAG_W-1:0]  match_tag
);

  logic           f_push;
  logic           f_full;
  rlt_pkg::item_t f_item;
  logic           b_valid;
  logic           b_pop;
  rlt_pkg::item_t b_item;

  rlt_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .range_begin (range_begin),
    .range_end   (range_end),
    .entry_tag   (entry_tag),
    .query_addr  (query_addr),
    .q_push      (f_push),
    .q_full      (f_full),
    .q_item      (f_item)
  );

  rlt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_item (f_item),
    .q_full  (f_full),
    .rd_en   (b_pop),
    .q_valid (b_valid),
    .rd_item (b_item)
  );

  rlt_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_item    (b_item),
    .q_pop     (b_pop),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .match_tag (match_tag)
  );

endmodule

### sv/rlt_front.sv
// front end: takes input words and works out the bucket of an insert
`timescale 1ns / 1ps

module rlt_front #(
  parameter int unsigned BUCKETS = rlt_pkg::BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       command,
  input  logic [rlt_pkg::ADDR_W-1:0] range_begin,
  input  logic [rlt_pkg::ADDR_W-1:0] range_end,
  input  logic [rlt_pkg::TAG_W-1:0]  entry_tag,
  input  logic [rlt_pkg::ADDR_W-1:0] query_addr,
  output logic                       q_push,
  input  logic                       q_full,
  output rlt_pkg::item_t             q_item
);

  localparam int unsigned AW    = rlt_pkg::ADDR_W;
  localparam int unsigned PW    = 2 * AW;
  localparam int unsigned REM_W = rlt_pkg::BKT_W + 1;
  localparam logic [REM_W-1:0] BKT_DIV = REM_W'(BUCKETS);
  // floor((2^32 - 1) / BUCKETS), quotient estimate is low by at most one
  localparam logic [AW-1:0] RECIP = AW'(PW'({AW{1'b1}}) / PW'(BUCKETS));

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_SUB  = 5'b00100,
    F_FIX  = 5'b01000,
    F_SEND = 5'b10000
  } fstate_t;

  fstate_t state;
  rlt_pkg::item_t hold;
  logic [AW-1:0] shift;
  logic [PW-1:0] mult;
  logic [REM_W:0] qlo;
  logic [REM_W:0] qb;
  logic [REM_W:0] diff;
  logic [REM_W:0] rem2;
  logic [REM_W:0] fixed;

  // remainder is below twice the divisor, so the low bits carry it exactly
  always_comb begin
    mult = PW'(shift) * PW'(RECIP);
    qb   = qlo * {1'b0, BKT_DIV};
    diff = shift[REM_W:0] - qb;
    if (rem2 >= {1'b0, BKT_DIV}) begin
      fixed = rem2 - {1'b0, BKT_DIV};
    end else begin
      fixed = rem2;
    end
  end

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_SEND) && !q_full;
  assign q_item = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            if (command == rlt_pkg::CMD_LOOKUP) begin
              state <= F_SEND;
            end else begin
              state <= F_MUL;
            end
          end
        end
        F_MUL: state <= F_SUB;
        F_SUB: state <= F_FIX;
        F_FIX: state <= F_SEND;
        F_SEND: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (push) begin
          hold.cmd  <= rlt_pkg::cmd_t'(command);
          hold.last <= range_end;
          hold.tag  <= entry_tag;
          hold.bkt  <= '0;
          if (command == rlt_pkg::CMD_LOOKUP) begin
            hold.addr <= query_addr;
          end else begin
            hold.addr <= range_begin;
          end
          shift <= range_begin;
        end
      end
      F_MUL: begin
        qlo <= mult[AW+REM_W:AW];
      end
      F_SUB: begin
        rem2 <= diff;
      end
      F_FIX: begin
        hold.bkt <= fixed[rlt_pkg::BKT_W-1:0];
      end
      F_SEND: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/rlt_queue.sv
// two-word queue between front and back
`timescale 1ns / 1ps

module rlt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rlt_pkg::item_t wr_item,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_valid,
  output rlt_pkg::item_t rd_item
);

  rlt_pkg::item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign q_full  = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 2'd1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

### sv/rlt_back.sv
// back end: range memory, insert and lookup scan, result register
`timescale 1ns / 1ps

module rlt_back #(
  parameter int unsigned ENTRIES = rlt_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  rlt_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [rlt_pkg::STAT_W-1:0] status,
  output logic [rlt_pkg::TAG_W-1:0]  match_tag
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SCAN = 2'b10
  } bstate_t;

  bstate_t state;

  logic [rlt_pkg::ADDR_W-1:0] mem_begin [ENTRIES];
  logic [rlt_pkg::ADDR_W-1:0] mem_end   [ENTRIES];
  logic [rlt_pkg::TAG_W-1:0]  mem_tag   [ENTRIES];
  logic [rlt_pkg::BKT_W-1:0]  mem_bkt   [ENTRIES];

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] scan_inc;
  logic issuing;
  logic issue;
  logic rd_v;
  logic rd_last;
  logic [rlt_pkg::ADDR_W-1:0] rd_begin;
  logic [rlt_pkg::ADDR_W-1:0] rd_end;
  logic [rlt_pkg::TAG_W-1:0]  rd_tag;
  logic [rlt_pkg::BKT_W-1:0]  rd_bkt;
  logic [rlt_pkg::ADDR_W-1:0] qa;

  logic found;
  logic [rlt_pkg::BKT_W-1:0] best_bkt;
  logic [rlt_pkg::TAG_W-1:0] best_tag;
  logic found_next;
  logic [rlt_pkg::BKT_W-1:0] best_bkt_next;
  logic [rlt_pkg::TAG_W-1:0] best_tag_next;

  logic res_valid;
  logic do_write;
  logic [IDX_W-1:0] wr_idx;

  assign empty    = !res_valid;
  assign q_pop    = (state == B_IDLE) && q_valid && !res_valid;
  assign do_write = q_pop && (q_item.cmd == rlt_pkg::CMD_INSERT)
                    && (used < CNT_W'(ENTRIES));
  assign wr_idx   = used[IDX_W-1:0];
  assign issue    = (state == B_SCAN) && issuing;
  assign scan_inc = scan_idx + CNT_W'(1);

  // later entries win ties in the same bucket
  always_comb begin
    found_next    = found;
    best_bkt_next = best_bkt;
    best_tag_next = best_tag;
    if (rd_v && (qa >= rd_begin) && (qa <= rd_end)) begin
      if (!found || (rd_bkt <= best_bkt)) begin
        found_next    = 1'b1;
        best_bkt_next = rd_bkt;
        best_tag_next = rd_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_begin[wr_idx] <= q_item.addr;
      mem_end[wr_idx]   <= q_item.last;
      mem_tag[wr_idx]   <= q_item.tag;
      mem_bkt[wr_idx]   <= q_item.bkt;
    end
    if (issue) begin
      rd_begin <= mem_begin[scan_idx[IDX_W-1:0]];
      rd_end   <= mem_end[scan_idx[IDX_W-1:0]];
      rd_tag   <= mem_tag[scan_idx[IDX_W-1:0]];
      rd_bkt   <= mem_bkt[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      used      <= '0;
      issuing   <= 1'b0;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            if (q_item.cmd == rlt_pkg::CMD_INSERT) begin
              res_valid <= 1'b1;
              match_tag <= '0;
              if (do_write) begin
                used   <= used + CNT_W'(1);
                status <= rlt_pkg::ST_INSERTED;
              end else begin
                status <= rlt_pkg::ST_FULL;
              end
            end else if (used == '0) begin
              res_valid <= 1'b1;
              match_tag <= '0;
              status    <= rlt_pkg::ST_MISS;
            end else begin
              state    <= B_SCAN;
              issuing  <= 1'b1;
              scan_idx <= '0;
              qa       <= q_item.addr;
              found    <= 1'b0;
            end
          end
        end
        B_SCAN: begin
          rd_v <= issue;
          if (issue) begin
            rd_last  <= (scan_inc == used);
            scan_idx <= scan_inc;
            if (scan_inc == used) begin
              issuing <= 1'b0;
            end
          end
          found    <= found_next;
          best_bkt <= best_bkt_next;
          best_tag <= best_tag_next;
          if (rd_v && rd_last) begin
            state     <= B_IDLE;
            rd_last   <= 1'b0;
            res_valid <= 1'b1;
            if (found_next) begin
              status    <= rlt_pkg::ST_HIT;
              match_tag <= best_tag_next;
            end else begin
              status    <= rlt_pkg::ST_MISS;
              match_tag <= '0;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
